### sv/cbes_pkg.sv
// ----------------------------------------------------------------------------
// cbes_pkg
// Shared types and constants of the cubic Bezier easing solver.
// ----------------------------------------------------------------------------
package cbes_pkg;

    // Internal datapath: signed, 24 fraction bits
    localparam int DW    = 40;
    localparam int IFRAC = 24;
    // Curve parameter s lies in 0 .. 2^24
    localparam int SW    = IFRAC + 1;
    // Quotient bits kept by the divider (larger quotients saturate s)
    localparam int QW    = IFRAC + 2;
    localparam int RW    = DW + QW;

    // Port widths
    localparam int IN_W  = 18;
    localparam int OUT_W = 19;
    localparam int CFG_W = 18;
    localparam int IDX_W = 2;

    localparam logic signed [DW-1:0] ONE     = DW'(64'sd1 <<< IFRAC);
    localparam logic signed [DW-1:0] TOL     = DW'(16);
    localparam logic signed [DW-1:0] OUT_MAX = DW'(262143);
    localparam logic signed [DW-1:0] OUT_MIN = -DW'(262144);

    // Register indexes
    localparam logic [IDX_W-1:0] CFG_X1 = 2'd0;
    localparam logic [IDX_W-1:0] CFG_Y1 = 2'd1;
    localparam logic [IDX_W-1:0] CFG_X2 = 2'd2;
    localparam logic [IDX_W-1:0] CFG_Y2 = 2'd3;

    // Reset values of the control points (Q2.16)
    localparam logic signed [CFG_W-1:0] RST_X1 = 18'sd16384;
    localparam logic signed [CFG_W-1:0] RST_Y1 = 18'sd6554;
    localparam logic signed [CFG_W-1:0] RST_X2 = 18'sd16384;
    localparam logic signed [CFG_W-1:0] RST_Y2 = 18'sd65536;

    typedef enum logic [5:0] {
        ST_IDLE = 6'b000001,
        ST_EVAL = 6'b000010,
        ST_XCHK = 6'b000100,
        ST_SCHK = 6'b001000,
        ST_DIV  = 6'b010000,
        ST_YOUT = 6'b100000
    } t_state;

    // Which polynomial the shared multiplier is evaluating
    typedef enum logic [1:0] {
        K_X     = 2'd0,
        K_SLOPE = 2'd1,
        K_Y     = 2'd2
    } t_kind;

    // Divider status toward the sequencer
    typedef struct packed {
        logic          done;
        logic          big;
        logic          neg;
        logic [QW-1:0] mag;
    } t_div_res;

endpackage

### sv/cubic_bezier_easing_solver_unit.sv
// ----------------------------------------------------------------------------
// cubic_bezier_easing_solver_unit
// Solves x(s) = t on a unit cubic Bezier curve and returns y(s).
// ----------------------------------------------------------------------------
// Each Newton step evaluates x, checks it, evaluates the slope, checks it
// and runs the divider (which produces one quotient bit a cycle); each
// bisection step and the final y evaluation use the shared multiplier.
// The next input is taken only once the block is back in IDLE.
// Synchronous active-low reset sets the control points to their defaults.
module cubic_bezier_easing_solver_unit
    import cbes_pkg::*;
#(
    parameter int FRAC_BITS    = 16,
    parameter int NEWTON_STEPS = 8,
    parameter int BISECT_STEPS = 32
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_progress_valid,
    output logic                    o_progress_stall,
    input  logic signed [IN_W-1:0]  i_progress,
    output logic                    o_eased_valid,
    input  logic                    i_eased_stall,
    output logic signed [OUT_W-1:0] o_eased_value,
    input  logic                    i_cfg_valid,
    output logic                    o_cfg_ready,
    input  logic [IDX_W-1:0]        i_cfg_index,
    input  logic signed [CFG_W-1:0] i_cfg_data
);

    localparam int SH = IFRAC - FRAC_BITS;
    localparam logic signed [DW-1:0] HALF = (SH == 0) ? DW'(0) : DW'(64'sd1 <<< (SH - 1));
    localparam int NCW = $clog2(NEWTON_STEPS + 1);
    localparam int BCW = $clog2(BISECT_STEPS + 1);
    localparam logic [SW-1:0] S_ONE = SW'(1) << IFRAC;

    t_state r_state;
    t_kind  r_kind;
    logic [1:0] r_ph;
    logic r_bis;
    logic [NCW-1:0] r_ncnt;
    logic [BCW-1:0] r_bcnt;

    logic signed [CFG_W-1:0] r_x1, r_y1, r_x2, r_y2;
    logic signed [DW-1:0] r_ax, r_bx, r_cx, r_ay, r_by, r_cy;
    logic signed [DW-1:0] r_t;
    logic signed [DW-1:0] r_err;
    logic [SW-1:0] r_s, r_low, r_high;
    logic r_ovld;
    logic signed [OUT_W-1:0] r_out;

    logic signed [DW-1:0] w_prod;
    logic signed [DW-1:0] w_ma, w_mb;
    logic w_men;
    logic w_last;
    t_div_res w_div;
    logic w_dstart;

    logic signed [DW-1:0] w_x1, w_y1, w_x2, w_y2, w_dx, w_dy;
    logic signed [DW-1:0] w_cx, w_cy, w_bx, w_by, w_pin, w_tin;
    logic signed [DW-1:0] w_diff, w_slope, w_rnd;
    logic w_tol_d, w_tol_s;
    logic [SW:0] w_mid_sum;
    logic [SW-1:0] w_nlow, w_nhigh;
    logic signed [SW+2:0] w_sn;
    logic [SW-1:0] w_snew;
    logic signed [OUT_W-1:0] w_sat;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x1 <= RST_X1;
            r_y1 <= RST_Y1;
            r_x2 <= RST_X2;
            r_y2 <= RST_Y2;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_X1:  r_x1 <= i_cfg_data;
                CFG_Y1:  r_y1 <= i_cfg_data;
                CFG_X2:  r_x2 <= i_cfg_data;
                CFG_Y2:  r_y2 <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign o_cfg_ready = 1'b1;

    // coefficients and clamped progress, latched on input transfer
    always_comb begin
        w_x1  = DW'(r_x1) <<< SH;
        w_y1  = DW'(r_y1) <<< SH;
        w_x2  = DW'(r_x2) <<< SH;
        w_y2  = DW'(r_y2) <<< SH;
        w_dx  = w_x2 - w_x1;
        w_dy  = w_y2 - w_y1;
        w_cx  = w_x1 + (w_x1 <<< 1);
        w_cy  = w_y1 + (w_y1 <<< 1);
        w_bx  = w_dx + (w_dx <<< 1) - w_cx;
        w_by  = w_dy + (w_dy <<< 1) - w_cy;
        w_pin = DW'(i_progress) <<< SH;
        w_tin = w_pin[DW-1] ? DW'(0) : ((w_pin > ONE) ? ONE : w_pin);
    end

    // operand select for the shared multiplier
    always_comb begin
        w_men  = (r_state == ST_EVAL);
        w_last = (r_kind == K_SLOPE) ? (r_ph == 2'd1) : (r_ph == 2'd2);
        w_ma   = w_prod;
        w_mb   = '0;
        unique case (r_kind)
            K_X: begin
                w_ma = (r_ph == 2'd0) ? r_ax : w_prod;
                w_mb = (r_ph == 2'd0) ? DW'(0) : ((r_ph == 2'd1) ? r_bx : r_cx);
            end
            K_Y: begin
                w_ma = (r_ph == 2'd0) ? r_ay : w_prod;
                w_mb = (r_ph == 2'd0) ? DW'(0) : ((r_ph == 2'd1) ? r_by : r_cy);
            end
            K_SLOPE: begin
                w_ma = (r_ph == 2'd0) ? r_ax : w_prod;
                w_mb = (r_ph == 2'd0) ? (r_ax <<< 1) : (r_bx <<< 1);
            end
            default: ;
        endcase
    end

    cbes_mul u_mul (
        .i_clk (i_clk),
        .i_en  (w_men),
        .i_a   (w_ma),
        .i_b   (w_mb),
        .i_s   (r_s),
        .o_p   (w_prod)
    );

    // checks, bisection midpoint, Newton update, output rounding
    always_comb begin
        w_diff    = w_prod - r_t;
        w_slope   = w_prod + r_cx;
        w_tol_d   = (w_diff > -TOL) && (w_diff < TOL);
        w_tol_s   = (w_slope > -TOL) && (w_slope < TOL);
        w_nlow    = (w_prod < r_t) ? r_s : r_low;
        w_nhigh   = (w_prod < r_t) ? r_high : r_s;
        w_mid_sum = {1'b0, w_nlow} + {1'b0, w_nhigh};
        w_sn      = w_div.neg ? ((SW+3)'(r_s) + (SW+3)'(w_div.mag))
                              : ((SW+3)'(r_s) - (SW+3)'(w_div.mag));
        if (w_div.big) begin
            w_snew = w_div.neg ? S_ONE : '0;
        end else if (w_sn[SW+2]) begin
            w_snew = '0;
        end else if (w_sn > (SW+3)'(S_ONE)) begin
            w_snew = S_ONE;
        end else begin
            w_snew = w_sn[SW-1:0];
        end
        w_rnd = (w_prod + HALF) >>> SH;
        if (w_rnd < OUT_MIN) begin
            w_sat = OUT_W'(OUT_MIN);
        end else if (w_rnd > OUT_MAX) begin
            w_sat = OUT_W'(OUT_MAX);
        end else begin
            w_sat = w_rnd[OUT_W-1:0];
        end
    end

    assign w_dstart = (r_state == ST_SCHK) && !w_tol_s;

    cbes_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_dstart),
        .i_err   (r_err),
        .i_slope (w_slope),
        .o_res   (w_div)
    );

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_kind  <= K_X;
            r_ph    <= '0;
            r_bis   <= 1'b0;
            r_ncnt  <= '0;
            r_bcnt  <= '0;
            r_ovld  <= 1'b0;
        end else begin
            // result register: loaded from YOUT, cleared on output transfer
            if (r_state == ST_YOUT && (!r_ovld || !i_eased_stall)) begin
                r_ovld <= 1'b1;
            end else if (o_eased_valid && !i_eased_stall) begin
                r_ovld <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (i_progress_valid) begin
                        r_state <= ST_EVAL;
                        r_kind  <= K_X;
                        r_ph    <= '0;
                        r_bis   <= 1'b0;
                        r_ncnt  <= '0;
                        r_bcnt  <= '0;
                    end
                end
                ST_EVAL: begin
                    r_ph <= w_last ? 2'd0 : r_ph + 2'd1;
                    if (w_last) begin
                        unique case (r_kind)
                            K_X:     r_state <= ST_XCHK;
                            K_SLOPE: r_state <= ST_SCHK;
                            K_Y:     r_state <= ST_YOUT;
                            default: r_state <= ST_YOUT;
                        endcase
                    end
                end
                ST_XCHK: begin
                    r_state <= ST_EVAL;
                    if (w_tol_d) begin
                        r_kind <= K_Y;
                    end else if (!r_bis) begin
                        r_kind <= K_SLOPE;
                    end else begin
                        r_bcnt <= r_bcnt + BCW'(1);
                        r_kind <= (r_bcnt == BCW'(BISECT_STEPS - 1)) ? K_Y : K_X;
                    end
                end
                ST_SCHK: begin
                    if (w_tol_s) begin
                        r_state <= ST_EVAL;
                        r_kind  <= K_X;
                        r_bis   <= 1'b1;
                    end else begin
                        r_state <= ST_DIV;
                    end
                end
                ST_DIV: begin
                    if (w_div.done) begin
                        r_ncnt  <= r_ncnt + NCW'(1);
                        r_state <= ST_EVAL;
                        r_kind  <= K_X;
                        if (r_ncnt == NCW'(NEWTON_STEPS - 1)) begin
                            r_bis <= 1'b1;
                        end
                    end
                end
                ST_YOUT: begin
                    if (!r_ovld || !i_eased_stall) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            ST_IDLE: begin
                if (i_progress_valid) begin
                    r_cx <= w_cx;
                    r_cy <= w_cy;
                    r_bx <= w_bx;
                    r_by <= w_by;
                    r_ax <= ONE - w_cx - w_bx;
                    r_ay <= ONE - w_cy - w_by;
                    r_t  <= w_tin;
                    r_s  <= w_tin[SW-1:0];
                end
            end
            ST_XCHK: begin
                if (!w_tol_d && !r_bis) begin
                    r_err <= w_diff;
                end else if (!w_tol_d) begin
                    r_low  <= w_nlow;
                    r_high <= w_nhigh;
                    r_s    <= w_mid_sum[SW:1];
                end
            end
            ST_SCHK: begin
                // flat slope: bisection restarts from t
                if (w_tol_s) begin
                    r_s    <= r_t[SW-1:0];
                    r_low  <= '0;
                    r_high <= S_ONE;
                end
            end
            ST_DIV: begin
                if (w_div.done) begin
                    if (r_ncnt == NCW'(NEWTON_STEPS - 1)) begin
                        r_s    <= r_t[SW-1:0];
                        r_low  <= '0;
                        r_high <= S_ONE;
                    end else begin
                        r_s <= w_snew;
                    end
                end
            end
            ST_YOUT: begin
                if (!r_ovld || !i_eased_stall) begin
                    r_out <= w_sat;
                end
            end
            default: ;
        endcase
    end

    assign o_progress_stall = (r_state != ST_IDLE);
    assign o_eased_valid    = r_ovld;
    assign o_eased_value    = r_out;

    // s never leaves [0,1]
    a_s_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_IDLE) |-> (r_s <= S_ONE))
        else $error("curve parameter out of range");

    // Newton count stays within its bound
    a_ncnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ncnt <= NCW'(NEWTON_STEPS))
        else $error("Newton step count overrun");

    // bisection bracket stays ordered
    a_bracket: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_bis && r_state == ST_XCHK) |-> (r_low <= r_high))
        else $error("bisection bracket inverted");

    // an input transfer starts an x evaluation
    a_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_progress_valid && !o_progress_stall) |=> (r_state == ST_EVAL && r_kind == K_X))
        else $error("input transfer did not start solving");

endmodule

### sv/cbes_mul.sv
// ----------------------------------------------------------------------------
// cbes_mul
// Shared multiply unit: p = round((a + b) * s / 2^24), registered.
// ----------------------------------------------------------------------------
module cbes_mul
    import cbes_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_en,
    input  logic signed [DW-1:0] i_a,
    input  logic signed [DW-1:0] i_b,
    input  logic [SW-1:0]        i_s,
    output logic signed [DW-1:0] o_p
);

    localparam int PW = DW + SW + 1;

    logic signed [DW-1:0] w_sum;
    logic signed [PW-1:0] w_prod;
    logic signed [PW-1:0] w_rnd;
    logic signed [DW-1:0] r_p;

    // pre-add, multiply, round half up
    always_comb begin
        w_sum  = i_a + i_b;
        w_prod = PW'(w_sum) * PW'($signed({1'b0, i_s}));
        w_rnd  = (w_prod + (PW'(1) <<< (IFRAC - 1))) >>> IFRAC;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p <= w_rnd[DW-1:0];
        end
    end

    assign o_p = r_p;

endmodule

### sv/cbes_div.sv
// ----------------------------------------------------------------------------
// cbes_div
// Restoring divider for the Newton step: (err * 2^24) / slope, truncated.
// ----------------------------------------------------------------------------
module cbes_div
    import cbes_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic signed [DW-1:0] i_err,
    input  logic signed [DW-1:0] i_slope,
    output t_div_res             o_res
);

    localparam int CW = $clog2(QW);

    logic [DW-1:0] w_a;
    logic [DW-1:0] w_d;
    logic          w_ge;
    logic          w_big;

    logic          r_busy;
    logic          r_done;
    logic [CW-1:0] r_cnt;
    logic [RW-1:0] r_rem;
    logic [RW-1:0] r_dvs;
    logic [QW-1:0] r_q;
    logic          r_neg;
    logic          r_big;

    // operand magnitudes
    always_comb begin
        w_a   = i_err[DW-1] ? DW'(-i_err) : DW'(i_err);
        w_d   = i_slope[DW-1] ? DW'(-i_slope) : DW'(i_slope);
        w_ge  = (r_rem >= r_dvs);
        // quotient of 2^26 or more only pins s to an end
        w_big = ({2'b00, w_a} >= {w_d, 2'b00});
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            if (i_start) begin
                r_cnt  <= '0;
                r_done <= w_big;
                r_busy <= !w_big;
            end else if (r_busy) begin
                r_cnt  <= r_cnt + CW'(1);
                r_done <= (r_cnt == CW'(QW - 1));
                r_busy <= (r_cnt != CW'(QW - 1));
            end else begin
                r_done <= 1'b0;
            end
        end
    end

    // datapath: one quotient bit per cycle
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_neg <= i_err[DW-1] ^ i_slope[DW-1];
            r_big <= w_big;
            r_rem <= RW'(w_a) << IFRAC;
            r_dvs <= RW'(w_d) << (QW - 1);
            r_q   <= '0;
        end else if (r_busy) begin
            if (w_ge) begin
                r_rem <= r_rem - r_dvs;
            end
            r_q   <= {r_q[QW-2:0], w_ge};
            r_dvs <= r_dvs >> 1;
        end
    end

    assign o_res.done = r_done;
    assign o_res.big  = r_big;
    assign o_res.neg  = r_neg;
    assign o_res.mag  = r_q;

endmodule

### verif/tb_cubic_bezier_easing_solver_unit.sv
// ----------------------------------------------------------------------------
// tb_cubic_bezier_easing_solver_unit
// Self-checking bench: predicts y(s) of the easing curve for every progress
// transfer, compares each eased transfer in order, sweeps control points.
// ----------------------------------------------------------------------------
module tb_cubic_bezier_easing_solver_unit
    import cbes_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int  WDOG_LIMIT = 20000;
    localparam int  IDLE_TAIL  = 600;

    logic                    i_clk = 1'b0;
    logic                    i_rst_n = 1'b0;
    logic                    i_progress_valid = 1'b0;
    logic                    o_progress_stall;
    logic signed [IN_W-1:0]  i_progress = '0;
    logic                    o_eased_valid;
    logic                    i_eased_stall = 1'b0;
    logic signed [OUT_W-1:0] o_eased_value;
    logic                    i_cfg_valid = 1'b0;
    logic                    o_cfg_ready;
    logic [IDX_W-1:0]        i_cfg_index = '0;
    logic signed [CFG_W-1:0] i_cfg_data = '0;

    // Control points as the predictor sees them
    logic signed [CFG_W-1:0] pt_x1 = RST_X1, pt_y1 = RST_Y1;
    logic signed [CFG_W-1:0] pt_x2 = RST_X2, pt_y2 = RST_Y2;

    logic signed [OUT_W-1:0] eased_q[$];
    int  n_err = 0;
    int  idle_cycles = 0;
    bit  calm = 1'b0;

    always #1 i_clk = ~i_clk;

    cubic_bezier_easing_solver_unit DUT (.*);

    // Q24 product, rounded half up
    function automatic longint q_mul(longint a, longint b);
        return (a * b + (64'sd1 <<< 23)) >>> 24;
    endfunction

    function automatic longint clamp_unit(longint v);
        return v < 0 ? 0 : (v > (64'sd1 <<< 24) ? (64'sd1 <<< 24) : v);
    endfunction

    function automatic longint horner(longint a, longint b, longint c, longint s);
        return q_mul(q_mul(q_mul(a, s) + b, s) + c, s);
    endfunction

    function automatic longint abs_q(longint v);
        return v < 0 ? -v : v;
    endfunction

    function automatic logic signed [OUT_W-1:0] ease_of(logic signed [IN_W-1:0] p);
        longint one, x1, y1, x2, y2, cx, cy, bx, by, ax, ay;
        longint t, s, err, slope, lo, hi, x, y, r;
        bit solved;
        one = 64'sd1 <<< 24;
        x1 = longint'(pt_x1) * 256; y1 = longint'(pt_y1) * 256;
        x2 = longint'(pt_x2) * 256; y2 = longint'(pt_y2) * 256;
        cx = 3 * x1; cy = 3 * y1;
        bx = 3 * (x2 - x1) - cx; by = 3 * (y2 - y1) - cy;
        ax = one - cx - bx; ay = one - cy - by;
        t = clamp_unit(longint'(p) * 256);
        s = t;
        solved = 1'b0;
        for (int i = 0; i < 8; i++) begin
            err = horner(ax, bx, cx, s) - t;
            if (abs_q(err) < 16) begin
                solved = 1'b1;
                break;
            end
            slope = q_mul(q_mul(3 * ax, s) + 2 * bx, s) + cx;
            if (abs_q(slope) < 16) break;
            s = clamp_unit(s - (err * one) / slope);
        end
        if (!solved) begin
            lo = 0; hi = one; s = t;
            for (int i = 0; i < 32; i++) begin
                x = horner(ax, bx, cx, s);
                if (abs_q(x - t) < 16) break;
                if (x < t) lo = s;
                else hi = s;
                s = (lo + hi) >>> 1;
            end
        end
        y = horner(ay, by, cy, s);
        r = (y + 128) >>> 8;
        if (r < -262144) r = -262144;
        if (r > 262143) r = 262143;
        return OUT_W'(r);
    endfunction

    // Random stall bursts on the result side
    initial begin
        forever begin
            @(posedge i_clk);
            if (!calm && $urandom_range(0, 5) == 0) begin
                i_eased_stall <= 1'b1;
                repeat ($urandom_range(1, 8)) @(posedge i_clk);
                i_eased_stall <= 1'b0;
            end
        end
    end

    // Result checker
    always @(posedge i_clk) begin
        if (i_rst_n && o_eased_valid && !i_eased_stall) begin
            if (eased_q.size() == 0) begin
                $error("eased_value: unexpected transfer, actual %0d", o_eased_value);
                n_err++;
            end else begin
                if (o_eased_value !== eased_q[0]) begin
                    $error("eased_value: expected %0d actual %0d",
                           eased_q[0], o_eased_value);
                    n_err++;
                end
                void'(eased_q.pop_front());
            end
        end
    end

    // Watchdog on cycles without any transfer
    always @(posedge i_clk) begin
        if ((i_progress_valid && !o_progress_stall) ||
            (o_eased_valid && !i_eased_stall) || (i_cfg_valid && o_cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WDOG_LIMIT) begin
            $display("** cubic_bezier_easing_solver_unit: FAILED **");
            $finish;
        end
    end

    // One progress transfer; returns after it, while the block is still busy
    task automatic send_progress(logic signed [IN_W-1:0] p);
        if (!calm && $urandom_range(0, 4) == 0)
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
        i_progress_valid <= 1'b1;
        i_progress <= p;
        do @(posedge i_clk); while (o_progress_stall);
        eased_q.push_back(ease_of(p));
        i_progress_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic drain();
        while (eased_q.size() != 0) @(posedge i_clk);
        repeat (IDLE_TAIL) @(posedge i_clk);
    endtask

    task automatic write_point(logic [IDX_W-1:0] idx, logic signed [CFG_W-1:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        case (idx)
            CFG_X1: pt_x1 = val;
            CFG_Y1: pt_y1 = val;
            CFG_X2: pt_x2 = val;
            CFG_Y2: pt_y2 = val;
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    task automatic set_curve(int x1, int y1, int x2, int y2);
        drain();
        write_point(CFG_X1, CFG_W'(x1));
        write_point(CFG_Y1, CFG_W'(y1));
        write_point(CFG_X2, CFG_W'(x2));
        write_point(CFG_Y2, CFG_W'(y2));
    endtask

    // Clamp edges, endpoints, all-ones/all-zeros progress codes and interior points
    task automatic test_directed_edges();
        int vals[] = '{-131072, 131071, -1, 0, 1, 65535, 65536, 65537,
                       32768, 16384, 49152, 21845};
        foreach (vals[i]) send_progress(IN_W'(vals[i]));
    endtask

    // Control extremes: x outside [0,1], flat slope, overshooting y
    task automatic test_curve_extremes();
        set_curve(0, 0, 65536, 65536);       // linear
        send_progress(18'sd12345);
        send_progress(18'sd65536);
        set_curve(-131072, 131071, 131071, -131072);
        for (int i = 0; i < 4; i++) send_progress(IN_W'(i * 21845));
        set_curve(0, 131071, 65536, 131071);  // y overshoot
        send_progress(18'sd32768);
        set_curve(0, 0, 0, 0);                // flat slope at s=0..
        send_progress(18'sd100);
        send_progress(18'sd0);
        set_curve(65536, 0, 0, 65536);        // flat in the middle
        send_progress(18'sd32768);
        send_progress(18'sd32700);
    endtask

    task automatic test_random_curves(int n_sets, int per_set);
        for (int k = 0; k < n_sets; k++) begin
            if ($urandom_range(0, 3) == 0)
                set_curve($urandom_range(0, 262143) - 131072,
                          $urandom_range(0, 262143) - 131072,
                          $urandom_range(0, 262143) - 131072,
                          $urandom_range(0, 262143) - 131072);
            else
                set_curve($urandom_range(0, 65536), $urandom_range(0, 98304) - 16384,
                          $urandom_range(0, 65536), $urandom_range(0, 98304) - 16384);
            for (int i = 0; i < per_set; i++) begin
                if ($urandom_range(0, 7) == 0)
                    send_progress(IN_W'($urandom()));
                else
                    send_progress(IN_W'($urandom_range(0, 65536)));
            end
            // Hold off until the pipeline is empty now and then
            if (k % 10 == 3)
                while (eased_q.size() != 0) @(posedge i_clk);
        end
    endtask

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed_edges();
        test_curve_extremes();
        test_random_curves(50, 20);
        calm = 1'b1;
        test_random_curves(8, 20);
        drain();
        if (n_err == 0)
            $display("** cubic_bezier_easing_solver_unit: PASSED **");
        else
            $display("** cubic_bezier_easing_solver_unit: FAILED **");
        $finish;
    end

endmodule
